// File: rtl/asr_envelope_vca_defines.svh
// Assertion macros for the envelope VCA block.
`ifndef ASR_ENVELOPE_VCA_DEFINES_SVH
`define ASR_ENVELOPE_VCA_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, checked on every rising edge outside reset.
`define ASR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication in the same cycle.
`define ASR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASR_ASSERT(label, clk, rst, prop, msg)
`define ASR_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/asr_env_pkg.sv
// Types and constants shared by the envelope VCA modules.
`default_nettype none

package asr_env_pkg;

  localparam int CH_W       = 4;
  localparam int SAMPLE_W   = 24;
  localparam int LEVEL_W    = 24;
  localparam int GAIN_W     = 17;
  localparam int PULSE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 24'd8388608;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd65536;

  localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 24'd8388607;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 3'd4;

  // Register values after reset.
  localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP  = 24'd17;
  localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP = 24'd17;
  localparam logic [GAIN_W-1:0]  RST_SUSTAIN_GAIN = 17'd65536;
  localparam logic [PULSE_W-1:0] RST_PULSE_LENGTH = 16'd48;

  typedef enum logic [1:0] {
    ST_ATTACK  = 2'd0,
    ST_RELEASE = 2'd1,
    ST_SUSTAIN = 2'd2
  } stage_t;

  // One channel's word in the state memory.
  typedef struct packed {
    stage_t              stage;
    logic [LEVEL_W-1:0]  level;
    logic                last_gate;
    logic [PULSE_W-1:0]  pulse_left;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    stage:      ST_RELEASE,
    level:      '0,
    last_gate:  1'b0,
    pulse_left: '0
  };

  // Hand-over from the state update to the VCA multiplier pipeline.
  typedef struct packed {
    logic                valid;
    logic [CH_W-1:0]     channel;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [LEVEL_W-1:0]  level;
    logic [GAIN_W-1:0]   gain;
    logic                end_pulse;
  } vca_req_t;

endpackage

`default_nettype wire

// File: rtl/asr_env_in_if.sv
// Input channel: one audio sample for one voice channel per beat.
`default_nettype none

interface asr_env_in_if import asr_env_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic                       gate_level;
  logic                       manual_level;
  logic                       frame_end;
  logic signed [SAMPLE_W-1:0] audio_sample;

  modport source (
    output valid, channel, gate_level, manual_level, frame_end, audio_sample,
    input  ready
  );

  modport sink (
    input  valid, channel, gate_level, manual_level, frame_end, audio_sample,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/asr_env_out_if.sv
// Output channel: one scaled sample with its envelope state per beat.
`default_nettype none

interface asr_env_out_if import asr_env_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            out_channel;
  logic signed [SAMPLE_W-1:0] audio_out;
  logic [LEVEL_W-1:0]         envelope_level;
  logic                       end_pulse;

  modport source (
    output valid, out_channel, audio_out, envelope_level, end_pulse,
    input  ready
  );

  modport sink (
    input  valid, out_channel, audio_out, envelope_level, end_pulse,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/asr_env_mem.sv
// Per-channel state memory with registered synchronous read and reset valid bits.
`default_nettype none

module asr_env_mem import asr_env_pkg::*; #(
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] written;
  entry_t           rd_data;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as the reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_entry = rd_written ? rd_data : ENTRY_RESET;

endmodule

`default_nettype wire

// File: rtl/asr_env_vca.sv
// VCA multiplier pipeline: sample magnitude times level times gain, then output register.
`default_nettype none

module asr_env_vca import asr_env_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  vca_req_t             req,
  output logic                 advance,
  asr_env_out_if.source        result_out
);

  localparam int PROD_W = SAMPLE_W + LEVEL_W;
  localparam int HALF_W = PROD_W / 2;
  localparam int PP_W   = HALF_W + GAIN_W;
  localparam int SUM_W  = PROD_W + GAIN_W;
  localparam int SHIFT  = LEVEL_W - 1 + GAIN_W - 1;

  vca_req_t                a_req;

  logic                    b_valid;
  logic [CH_W-1:0]         b_channel;
  logic                    b_neg;
  logic [LEVEL_W-1:0]      b_level;
  logic [GAIN_W-1:0]       b_gain;
  logic                    b_pulse;
  logic [PROD_W-1:0]       b_prod;

  logic                    c_valid;
  logic [CH_W-1:0]         c_channel;
  logic                    c_neg;
  logic [LEVEL_W-1:0]      c_level;
  logic                    c_pulse;
  logic [PP_W-1:0]         c_pp_lo;
  logic [PP_W-1:0]         c_pp_hi;

  logic [SUM_W-1:0]        full;
  logic [SAMPLE_W-1:0]     mag_out;
  logic [SAMPLE_W-1:0]     audio_next;

  // The whole pipeline moves together; a stalled output freezes every stage.
  assign advance = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_req.valid      <= 1'b0;
      b_valid          <= 1'b0;
      c_valid          <= 1'b0;
      result_out.valid <= 1'b0;
    end else if (advance) begin
      a_req            <= req;
      b_valid          <= a_req.valid;
      c_valid          <= b_valid;
      result_out.valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_channel <= a_req.channel;
      b_neg     <= a_req.neg;
      b_level   <= a_req.level;
      b_gain    <= a_req.gain;
      b_pulse   <= a_req.end_pulse;
      b_prod    <= PROD_W'(a_req.mag) * PROD_W'(a_req.level);

      // The wide product is split into two halves against the gain.
      c_channel <= b_channel;
      c_neg     <= b_neg;
      c_level   <= b_level;
      c_pulse   <= b_pulse;
      c_pp_lo   <= PP_W'(b_prod[HALF_W-1:0]) * PP_W'(b_gain);
      c_pp_hi   <= PP_W'(b_prod[PROD_W-1:HALF_W]) * PP_W'(b_gain);

      result_out.out_channel    <= c_channel;
      result_out.envelope_level <= c_level;
      result_out.end_pulse      <= c_pulse;
      result_out.audio_out      <= audio_next;
    end
  end

  assign full    = {c_pp_hi, {HALF_W{1'b0}}} + SUM_W'(c_pp_lo);
  assign mag_out = full[SHIFT+SAMPLE_W-1:SHIFT];

  // Truncation is on the magnitude, so the result rounds towards zero.
  always_comb begin
    if (c_neg) begin
      audio_next = ~mag_out + 24'd1;
    end else if (mag_out > SAMPLE_POS_MAX) begin
      audio_next = SAMPLE_POS_MAX;
    end else begin
      audio_next = mag_out;
    end
  end

endmodule

`default_nettype wire

// File: rtl/asr_envelope_vca.sv
// An accepted input beat is registered in the update stage, then in VCA stages a, b and c
// and the output register. Throughput: one item per cycle while the output is not stalled;
// a forwarding register covers the state memory read-modify-write for back-to-back items
// on one channel. An output stall freezes the whole pipeline and drops input ready.
// Reset (synchronous) restores the register defaults and marks every channel as
// release at level zero through per-entry valid bits; no clearing pass is needed.
`default_nettype none

`include "asr_envelope_vca_defines.svh"

module asr_envelope_vca import asr_env_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  asr_env_in_if.sink            sample_in,
  asr_env_out_if.source         result_out
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic                 trigger_mode;
  logic [LEVEL_W-1:0]   attack_step;
  logic [LEVEL_W-1:0]   release_step;
  logic [GAIN_W-1:0]    sustain_gain;
  logic [PULSE_W-1:0]   pulse_length;

  logic                 advance;
  logic                 accept;
  logic [AW+CH_W-1:0]   ch_ext;
  logic [AW-1:0]        rd_addr;
  logic                 ch_in_range;
  logic                 last_manual;

  // Update stage.
  logic                 s1_valid;
  logic [CH_W-1:0]      s1_channel;
  logic [AW-1:0]        s1_addr;
  logic                 s1_in_range;
  logic                 s1_gate;
  logic                 s1_manual;
  logic                 s1_last_manual;
  logic [SAMPLE_W-1:0]  s1_sample;

  entry_t               rd_entry;
  entry_t               cur;
  entry_t               wr_entry;
  logic                 wr_en;

  logic                 fwd_valid;
  logic [AW-1:0]        fwd_addr;
  entry_t               fwd_entry;

  logic                 g_lead;
  logic                 g_trail;
  logic                 m_lead;
  logic                 m_trail;
  stage_t               st;
  logic [LEVEL_W:0]     lv;
  logic [LEVEL_W:0]     lv_sum;
  logic [PULSE_W-1:0]   pl;

  vca_req_t             req;
  logic                 out_beyond;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_mode <= 1'b0;
      attack_step  <= RST_ATTACK_STEP;
      release_step <= RST_RELEASE_STEP;
      sustain_gain <= RST_SUSTAIN_GAIN;
      pulse_length <= RST_PULSE_LENGTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TRIGGER_MODE: trigger_mode <= cfg_data[0];
        CFG_ATTACK_STEP:  attack_step  <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE_STEP: release_step <= cfg_data[LEVEL_W-1:0];
        CFG_SUSTAIN_GAIN: sustain_gain <= cfg_data[GAIN_W-1:0];
        CFG_PULSE_LENGTH: pulse_length <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample_in.ready = advance;
  assign accept          = sample_in.valid && advance;
  assign ch_ext          = {{AW{1'b0}}, sample_in.channel};
  assign rd_addr         = ch_ext[AW-1:0];
  assign ch_in_range     = ({28'd0, sample_in.channel} < 32'(CHANNELS));

  asr_env_mem #(
    .DEPTH (CHANNELS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_entry (wr_entry)
  );

  // The manual gate's previous level, sampled at the last frame end, is taken for each item as it enters.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_manual <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept && sample_in.frame_end) begin
        last_manual <= sample_in.manual_level;
      end
      if (advance) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_channel     <= sample_in.channel;
      s1_addr        <= rd_addr;
      s1_in_range    <= ch_in_range;
      s1_gate        <= sample_in.gate_level;
      s1_manual      <= sample_in.manual_level;
      s1_last_manual <= last_manual;
      s1_sample      <= sample_in.audio_sample;
    end
  end

  assign wr_en = advance && s1_valid && s1_in_range;

  // The read for the next item happens at the same edge as this write, so the
  // last written entry is kept for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= wr_entry;
    end
  end

  assign cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_entry : rd_entry;

  always_comb begin
    m_lead  = s1_manual && !s1_last_manual;
    m_trail = !s1_manual && s1_last_manual;
    g_lead  = s1_gate && !cur.last_gate;
    g_trail = !s1_gate && cur.last_gate;
    st      = cur.stage;
    lv      = {1'b0, cur.level};
    pl      = cur.pulse_left;

    if (pl != '0) begin
      pl = pl - 16'd1;
    end

    if (trigger_mode) begin
      if (g_lead || m_lead) begin
        if (st == ST_RELEASE) begin
          st = ST_ATTACK;
        end else begin
          st = ST_RELEASE;
          pl = pulse_length;
        end
      end
    end else if (st == ST_RELEASE) begin
      if ((g_lead && !s1_manual) || (!s1_gate && m_lead)) begin
        st = ST_ATTACK;
      end
    end else if ((g_trail && !s1_manual) || (!s1_gate && m_trail)) begin
      st = ST_RELEASE;
    end

    lv_sum = lv + {1'b0, attack_step};

    unique case (st)
      ST_RELEASE: begin
        if (lv != '0) begin
          if ({1'b0, release_step} >= lv) begin
            lv = '0;
            pl = pulse_length;
          end else begin
            lv = lv - {1'b0, release_step};
          end
        end
      end
      ST_ATTACK: begin
        if (lv_sum >= {1'b0, LEVEL_ONE}) begin
          lv = {1'b0, LEVEL_ONE};
          st = ST_SUSTAIN;
        end else begin
          lv = lv_sum;
        end
      end
      default: ;
    endcase

    wr_entry.stage      = st;
    wr_entry.level      = lv[LEVEL_W-1:0];
    wr_entry.last_gate  = s1_gate;
    wr_entry.pulse_left = pl;
  end

  // A channel beyond the memory gives a zero level, so its audio comes out zero.
  always_comb begin
    req.valid     = s1_valid;
    req.channel   = s1_channel;
    req.neg       = s1_sample[SAMPLE_W-1];
    req.mag       = s1_sample[SAMPLE_W-1] ? (~s1_sample + 24'd1) : s1_sample;
    req.level     = s1_in_range ? lv[LEVEL_W-1:0] : '0;
    req.gain      = (sustain_gain > GAIN_ONE) ? GAIN_ONE : sustain_gain;
    req.end_pulse = s1_in_range && (pl != '0);
  end

  asr_env_vca u_vca (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .result_out (result_out)
  );

  assign out_beyond = ({28'd0, result_out.out_channel} >= 32'(CHANNELS));

  `ASR_ASSERT_IMP(a_level_in_range, clk, rst, wr_en, wr_entry.level <= LEVEL_ONE, "envelope level above one written back")
  `ASR_ASSERT_IMP(a_sustain_at_one, clk, rst, wr_en && (wr_entry.stage == ST_SUSTAIN), wr_entry.level == LEVEL_ONE, "sustain stage written with level below one")
  `ASR_ASSERT_IMP(a_beyond_is_zero, clk, rst, result_out.valid && out_beyond, (result_out.envelope_level == '0) && (result_out.audio_out == '0) && !result_out.end_pulse, "result for absent channel is not zero")
  `ASR_ASSERT(a_no_write_beyond, clk, rst, !(s1_valid && !s1_in_range && wr_en), "state written for an absent channel")

endmodule

`default_nettype wire
